// File: rtl/core/tpba_pkg.sv
// types, codes and helpers shared by the token pool branch accounting core
package tpba_pkg;

  // count width and saturation limit
  localparam int CNT_W = 48;
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // input field widths
  localparam int CMD_W    = 3;
  localparam int BRANCH_W = 4;
  localparam int TYPE_W   = 2;

  // stream data widths, padded to whole bytes
  localparam int IN_BITS   = CMD_W + BRANCH_W + TYPE_W + CNT_W;
  localparam int IN_DATA_W = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS   = 1 + 1 + CNT_W + CNT_W;
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam int POOL_REGS = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_REFILL_LEVEL = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POOL_MEMORY  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_POOL_CPU     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_POOL_GPU     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_POOL_NETWORK = 3'd4;

  // watermark after reset
  localparam logic [CNT_W-1:0] REFILL_RESET = 48'd1024;

  // commands
  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC     = 3'd0,
    CMD_FREE      = 3'd1,
    CMD_RECONCILE = 3'd2,
    CMD_RELEASE   = 3'd3,
    CMD_RESERVE   = 3'd4,
    CMD_RELOAD    = 3'd5
  } cmd_t;

  // result status codes
  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_NO_FUND = 1'b1;

  // saturating add of two counts
  function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                               input logic [CNT_W-1:0] b);
    logic [CNT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CNT_W] ? CNT_MAX : s[CNT_W-1:0];
  endfunction

endpackage

// File: rtl/core/token_pool_branch_accounting_core.sv
// token pool with one bank and per-branch caches, one command per beat
//
//  channel | dir | handshake        | payload
//  s_      | in  | s_tvalid/tready  | s_tdata: cmd, branch_index, tok_kind, amount
//  m_      | out | m_tvalid/tready  | m_tdata: status, refilled, branch/bank counts
//  cfg_    | in  | cfg_we           | cfg_index, cfg_data
//
// a command beat is registered, worked out combinationally against the counters
// and its result lands in the output register: one command per cycle sustained
// while the output is not stalled. the bank counters and the addressed branch row
// are read and written back in that same cycle, so back-to-back commands on the
// same branch see each other. rst clears all counters and the watermark to 1024.
// a stalled output holds the command register, which then holds s_tready low.
module token_pool_branch_accounting_core
  import tpba_pkg::*;
#(
  parameter int BRANCHES    = 16,
  parameter int TOKEN_TYPES = 4
) (
  input  logic                    clk,
  input  logic                    rst,
  // command beat
  input  logic                    s_tvalid,
  output logic                    s_tready,
  // [2:0] cmd, [6:3] branch_index, [8:7] tok_kind, [56:9] amount
  input  logic [IN_DATA_W-1:0]    s_tdata,
  // result beat
  output logic                    m_tvalid,
  input  logic                    m_tready,
  // [0] status, [1] refilled, [49:2] branch_count_now, [97:50] bank_count_now
  output logic [OUT_DATA_W-1:0]   m_tdata,
  // configuration writes
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CNT_W-1:0]        cfg_data
);

  // index widths
  localparam int BW  = (BRANCHES > 1) ? $clog2(BRANCHES) : 1;
  localparam int TW  = (TOKEN_TYPES > 1) ? $clog2(TOKEN_TYPES) : 1;
  localparam int BCW = ($clog2(BRANCHES + 1) > BRANCH_W) ? $clog2(BRANCHES + 1) : BRANCH_W;
  localparam int TCW = ($clog2(TOKEN_TYPES + 1) > TYPE_W) ? $clog2(TOKEN_TYPES + 1) : TYPE_W;

  // configuration registers
  logic [CNT_W-1:0] refill_level;
  logic [CNT_W-1:0] pool [POOL_REGS];

  // counters
  logic [CNT_W-1:0] bank     [TOKEN_TYPES];
  logic [CNT_W-1:0] tokens   [BRANCHES][TOKEN_TYPES];
  logic [CNT_W-1:0] borrowed [BRANCHES][TOKEN_TYPES];
  logic [CNT_W-1:0] pending;

  // command register
  logic                cmd_valid;
  logic [CMD_W-1:0]    cmd_q;
  logic [BRANCH_W-1:0] branch_q;
  logic [TYPE_W-1:0]   type_q;
  logic [CNT_W-1:0]    amount_q;

  // result register
  logic                out_valid;
  logic                out_status;
  logic                out_refilled;
  logic [CNT_W-1:0]    out_branch;
  logic [CNT_W-1:0]    out_bank;

  logic advance;

  // decoded index
  logic [BCW-1:0] br_wide;
  logic [TCW-1:0] ty_wide;
  logic           idx_ok;
  logic [BW-1:0]  br;
  logic [TW-1:0]  ty;

  // next values of the touched state
  logic [CNT_W-1:0] row_tok      [TOKEN_TYPES];
  logic [CNT_W-1:0] row_bor      [TOKEN_TYPES];
  logic [CNT_W-1:0] row_tok_next [TOKEN_TYPES];
  logic [CNT_W-1:0] row_bor_next [TOKEN_TYPES];
  logic [CNT_W-1:0] bank_next    [TOKEN_TYPES];
  logic [CNT_W-1:0] reload_val   [TOKEN_TYPES];
  logic [CNT_W-1:0] rec_in       [TOKEN_TYPES];
  logic [CNT_W-1:0] rec_excess   [TOKEN_TYPES];
  logic [CNT_W-1:0] pending_next;
  logic             status_next;
  logic             refilled_next;

  // alloc and free helpers
  logic [CNT_W-1:0] cur_tok;
  logic [CNT_W-1:0] cur_bank;
  logic [CNT_W-1:0] fill;
  logic [CNT_W-1:0] tok_filled;
  logic [CNT_W-1:0] tok_freed;

  // handshakes
  assign advance  = cmd_valid && (!out_valid || m_tready);
  assign s_tready = !rst && (!cmd_valid || advance);
  assign m_tvalid = out_valid;
  assign m_tdata  = OUT_DATA_W'({out_bank, out_branch, out_refilled, out_status});

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      refill_level <= REFILL_RESET;
      for (int i = 0; i < POOL_REGS; i++) begin
        pool[i] <= '0;
      end
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_REFILL_LEVEL: refill_level <= cfg_data;
        CFG_POOL_MEMORY:  pool[0] <= cfg_data;
        CFG_POOL_CPU:     pool[1] <= cfg_data;
        CFG_POOL_GPU:     pool[2] <= cfg_data;
        CFG_POOL_NETWORK: pool[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // reload values per type, types beyond the pool registers load zero
  for (genvar g = 0; g < TOKEN_TYPES; g++) begin : g_reload
    if (g < POOL_REGS) begin : g_pool
      assign reload_val[g] = pool[g];
    end else begin : g_zero
      assign reload_val[g] = '0;
    end
  end

  // command register
  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (s_tready) begin
      cmd_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      cmd_q    <= s_tdata[CMD_W-1:0];
      branch_q <= s_tdata[CMD_W+BRANCH_W-1:CMD_W];
      type_q   <= s_tdata[CMD_W+BRANCH_W+TYPE_W-1:CMD_W+BRANCH_W];
      amount_q <= s_tdata[IN_BITS-1:CMD_W+BRANCH_W+TYPE_W];
    end
  end

  // index decode
  assign br_wide = BCW'(branch_q);
  assign ty_wide = TCW'(type_q);
  assign idx_ok  = (br_wide < BCW'(BRANCHES)) && (ty_wide < TCW'(TOKEN_TYPES));
  assign br      = br_wide[BW-1:0];
  assign ty      = ty_wide[TW-1:0];

  // addressed row and type
  always_comb begin
    for (int t = 0; t < TOKEN_TYPES; t++) begin
      row_tok[t] = tokens[br][t];
      row_bor[t] = borrowed[br][t];
    end
    cur_tok    = row_tok[ty];
    cur_bank   = bank[ty];
    fill       = (cur_bank < refill_level) ? cur_bank : refill_level;
    tok_filled = sat_add(cur_tok, fill);
    tok_freed  = sat_add(cur_tok, amount_q);
  end

  // reconcile inputs: the freed count stands in for the addressed type
  always_comb begin
    for (int t = 0; t < TOKEN_TYPES; t++) begin
      rec_in[t]     = (cmd_q == CMD_FREE && TW'(t) == ty) ? tok_freed : row_tok[t];
      rec_excess[t] = rec_in[t] - refill_level;
    end
  end

  // command execution
  always_comb begin
    for (int t = 0; t < TOKEN_TYPES; t++) begin
      row_tok_next[t] = row_tok[t];
      row_bor_next[t] = row_bor[t];
      bank_next[t]    = bank[t];
    end
    pending_next  = pending;
    status_next   = STATUS_OK;
    refilled_next = 1'b0;

    unique case (cmd_q)
      CMD_RELOAD: begin
        for (int t = 0; t < TOKEN_TYPES; t++) begin
          bank_next[t] = reload_val[t];
        end
      end
      CMD_ALLOC: begin
        if (!idx_ok) begin
          status_next = STATUS_NO_FUND;
        end else if (cur_tok >= amount_q) begin
          row_tok_next[ty] = cur_tok - amount_q;
        end else if (fill == '0) begin
          status_next = STATUS_NO_FUND;
        end else begin
          // refill from the bank, then retry the take
          refilled_next    = 1'b1;
          bank_next[ty]    = cur_bank - fill;
          row_bor_next[ty] = sat_add(row_bor[ty], fill);
          if (tok_filled >= amount_q) begin
            row_tok_next[ty] = tok_filled - amount_q;
          end else begin
            row_tok_next[ty] = tok_filled;
            status_next      = STATUS_NO_FUND;
          end
        end
      end
      CMD_FREE, CMD_RECONCILE: begin
        if (!idx_ok) begin
          status_next = STATUS_NO_FUND;
        end else begin
          if (cmd_q == CMD_FREE) begin
            row_tok_next[ty] = tok_freed;
          end
          // return excess above the watermark on every type
          if (cmd_q == CMD_RECONCILE || tok_freed > refill_level) begin
            for (int t = 0; t < TOKEN_TYPES; t++) begin
              if (rec_in[t] > refill_level) begin
                row_tok_next[t] = refill_level;
                row_bor_next[t] = (row_bor[t] > rec_excess[t]) ?
                                  row_bor[t] - rec_excess[t] : '0;
                bank_next[t]    = sat_add(bank[t], rec_excess[t]);
              end
            end
          end
        end
      end
      CMD_RELEASE: begin
        if (!idx_ok) begin
          status_next = STATUS_NO_FUND;
        end else begin
          for (int t = 0; t < TOKEN_TYPES; t++) begin
            bank_next[t]    = sat_add(bank[t], row_tok[t]);
            row_tok_next[t] = '0;
            row_bor_next[t] = '0;
          end
        end
      end
      CMD_RESERVE: begin
        if (!idx_ok || cur_bank < amount_q) begin
          status_next = STATUS_NO_FUND;
        end else begin
          bank_next[ty] = cur_bank - amount_q;
          pending_next  = sat_add(pending, amount_q);
        end
      end
      default: ;
    endcase
  end

  // counter update
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
      for (int t = 0; t < TOKEN_TYPES; t++) begin
        bank[t] <= '0;
      end
      for (int b = 0; b < BRANCHES; b++) begin
        for (int t = 0; t < TOKEN_TYPES; t++) begin
          tokens[b][t]   <= '0;
          borrowed[b][t] <= '0;
        end
      end
    end else if (advance) begin
      pending <= pending_next;
      for (int t = 0; t < TOKEN_TYPES; t++) begin
        bank[t] <= bank_next[t];
      end
      if (idx_ok) begin
        for (int t = 0; t < TOKEN_TYPES; t++) begin
          tokens[br][t]   <= row_tok_next[t];
          borrowed[br][t] <= row_bor_next[t];
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_status   <= status_next;
      out_refilled <= refilled_next;
      out_branch   <= idx_ok ? row_tok_next[ty] : '0;
      out_bank     <= idx_ok ? bank_next[ty] : '0;
    end
  end

endmodule

// File: tb/token_pool_branch_accounting_core_tb.sv
// testbench for the token pool branch accounting core: directed table, then random phases
`timescale 1ns / 100ps

module token_pool_branch_accounting_core_tb
  import tpba_pkg::*;
();

  localparam int NUM_BRANCHES = 16;
  localparam int NUM_TYPES    = 4;
  localparam int PHASES       = 6;
  localparam int PHASE_ITEMS  = 180;

  // command codes the block treats as no-ops
  localparam logic [CMD_W-1:0] CMD_SPARE_A = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_B = 3'd7;

  // one result beat, laid out as on m_tdata
  typedef struct packed {
    logic [CNT_W-1:0] bank_now;
    logic [CNT_W-1:0] branch_now;
    logic             refilled;
    logic             status;
  } account_reply_t;

  // one line of the directed table: a register write or a command
  typedef struct {
    logic                 is_reg;
    logic [CMD_W-1:0]     op;
    logic [BRANCH_W-1:0]  br;
    logic [TYPE_W-1:0]    ty;
    logic [CNT_W-1:0]     amt;
    logic                 known;
    account_reply_t       want;
  } table_row_t;

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CNT_W-1:0]      cfg_data;

  // shadow of the pool state and registers
  logic [CNT_W-1:0] bank_avail [NUM_TYPES];
  logic [CNT_W-1:0] branch_cnt [NUM_BRANCHES][NUM_TYPES];
  logic [CNT_W-1:0] branch_debt [NUM_BRANCHES][NUM_TYPES];
  logic [CNT_W-1:0] outbound_held;
  logic [CNT_W-1:0] watermark;
  logic [CNT_W-1:0] pool_init [NUM_TYPES];

  account_reply_t owed_replies[$];
  table_row_t     directed_rows[$];

  int fails;
  int cmds_sent;
  int refill_hits;
  int short_hits;
  int send_gap_pct;
  int recv_gap_pct;

  token_pool_branch_accounting_core u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #5 clk = ~clk;

  // run limit, far above the slowest correct run
  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

  // clamped add of two counts
  function automatic logic [CNT_W-1:0] add_clamped(input logic [CNT_W-1:0] a,
                                                   input logic [CNT_W-1:0] b);
    logic [CNT_W:0] total;
    total = a + b + {(CNT_W+1){1'b0}};
    if (total > {1'b0, CNT_MAX}) return CNT_MAX;
    return total[CNT_W-1:0];
  endfunction

  // push every type's surplus above the watermark back to the bank
  function automatic void return_excess(input logic [BRANCH_W-1:0] br);
    logic [CNT_W-1:0] excess;
    for (int t = 0; t < NUM_TYPES; t++) begin
      if (branch_cnt[br][t] > watermark) begin
        excess = branch_cnt[br][t] - watermark;
        branch_cnt[br][t] = watermark;
        branch_debt[br][t] = (branch_debt[br][t] > excess) ? branch_debt[br][t] - excess : '0;
        bank_avail[t] = add_clamped(bank_avail[t], excess);
      end
    end
  endfunction

  // apply one command to the shadow state and work out its reply
  function automatic account_reply_t apply_pool_cmd(input logic [CMD_W-1:0] c,
                                                    input logic [BRANCH_W-1:0] br,
                                                    input logic [TYPE_W-1:0] ty,
                                                    input logic [CNT_W-1:0] amt);
    account_reply_t r;
    logic [CNT_W-1:0] fill;
    r = '0;
    r.status = STATUS_OK;
    case (c)
      CMD_RELOAD: begin
        for (int t = 0; t < NUM_TYPES; t++) bank_avail[t] = pool_init[t];
      end
      CMD_ALLOC: begin
        if (branch_cnt[br][ty] >= amt) begin
          branch_cnt[br][ty] = branch_cnt[br][ty] - amt;
        end else begin
          fill = (bank_avail[ty] < watermark) ? bank_avail[ty] : watermark;
          if (fill == '0) begin
            r.status = STATUS_NO_FUND;
          end else begin
            bank_avail[ty] = bank_avail[ty] - fill;
            branch_cnt[br][ty] = add_clamped(branch_cnt[br][ty], fill);
            branch_debt[br][ty] = add_clamped(branch_debt[br][ty], fill);
            r.refilled = 1'b1;
            // the refill stays even when the retry still falls short
            if (branch_cnt[br][ty] >= amt) branch_cnt[br][ty] = branch_cnt[br][ty] - amt;
            else r.status = STATUS_NO_FUND;
          end
        end
      end
      CMD_FREE: begin
        branch_cnt[br][ty] = add_clamped(branch_cnt[br][ty], amt);
        if (branch_cnt[br][ty] > watermark) return_excess(br);
      end
      CMD_RECONCILE: return_excess(br);
      CMD_RELEASE: begin
        for (int t = 0; t < NUM_TYPES; t++) begin
          bank_avail[t] = add_clamped(bank_avail[t], branch_cnt[br][t]);
          branch_cnt[br][t] = '0;
          branch_debt[br][t] = '0;
        end
      end
      CMD_RESERVE: begin
        if (bank_avail[ty] < amt) begin
          r.status = STATUS_NO_FUND;
        end else begin
          bank_avail[ty] = bank_avail[ty] - amt;
          outbound_held = add_clamped(outbound_held, amt);
        end
      end
      default: ;
    endcase
    r.branch_now = branch_cnt[br][ty];
    r.bank_now = bank_avail[ty];
    return r;
  endfunction

  function automatic logic [CNT_W-1:0] rand48();
    logic [63:0] v;
    v = {$urandom, $urandom};
    return v[CNT_W-1:0];
  endfunction

  function automatic table_row_t cmd_row(input logic [CMD_W-1:0] op,
                                         input logic [BRANCH_W-1:0] br,
                                         input logic [TYPE_W-1:0] ty,
                                         input logic [CNT_W-1:0] amt);
    table_row_t row;
    row.is_reg = 1'b0;
    row.op = op;
    row.br = br;
    row.ty = ty;
    row.amt = amt;
    row.known = 1'b0;
    row.want = '0;
    return row;
  endfunction

  function automatic table_row_t known_row(input logic [CMD_W-1:0] op,
                                           input logic [BRANCH_W-1:0] br,
                                           input logic [TYPE_W-1:0] ty,
                                           input logic [CNT_W-1:0] amt,
                                           input logic st, input logic rf,
                                           input logic [CNT_W-1:0] bn,
                                           input logic [CNT_W-1:0] bk);
    table_row_t row;
    row = cmd_row(op, br, ty, amt);
    row.known = 1'b1;
    row.want.status = st;
    row.want.refilled = rf;
    row.want.branch_now = bn;
    row.want.bank_now = bk;
    return row;
  endfunction

  function automatic table_row_t reg_row(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [CNT_W-1:0] val);
    table_row_t row;
    row = cmd_row('0, '0, '0, val);
    row.is_reg = 1'b1;
    row.op = idx;
    return row;
  endfunction

  // weighted command mix, mostly alloc and free traffic
  function automatic logic [CMD_W-1:0] pick_cmd();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) return CMD_ALLOC;
    if (r < 60) return CMD_FREE;
    if (r < 68) return CMD_RECONCILE;
    if (r < 75) return CMD_RELEASE;
    if (r < 85) return CMD_RESERVE;
    if (r < 95) return CMD_RELOAD;
    if (r < 98) return CMD_SPARE_A;
    return CMD_SPARE_B;
  endfunction

  // amounts cluster around the watermark, with full-range and edge values mixed in
  function automatic logic [CNT_W-1:0] pick_amount();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) return CNT_W'($urandom_range(0, 3000));
    if (r < 55) return watermark + CNT_W'($urandom_range(0, 4)) - CNT_W'(2);
    if (r < 75) return rand48();
    if (r < 82) return CNT_MAX;
    if (r < 88) return '0;
    return rand48() >> $urandom_range(0, CNT_W-1);
  endfunction

  // hold off new commands until every reply is back and the pipe is empty
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (owed_replies.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CNT_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_REFILL_LEVEL) watermark = val;
    else if (idx >= CFG_POOL_MEMORY && idx <= CFG_POOL_NETWORK)
      pool_init[idx - CFG_POOL_MEMORY] = val;
  endtask

  // offer one command beat; called and returns at a falling edge
  task automatic send_cmd(input logic [CMD_W-1:0] c, input logic [BRANCH_W-1:0] br,
                          input logic [TYPE_W-1:0] ty, input logic [CNT_W-1:0] amt,
                          input logic known, input account_reply_t want);
    account_reply_t r;
    if ($urandom_range(0, 99) < send_gap_pct) begin
      s_tvalid <= 1'b0;
      do @(negedge clk); while ($urandom_range(0, 99) < send_gap_pct);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(IN_DATA_W-IN_BITS){1'b0}}, amt, ty, br, c};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    r = apply_pool_cmd(c, br, ty, amt);
    owed_replies.push_back(known ? want : r);
    cmds_sent++;
    if (r.refilled) refill_hits++;
    if (r.status == STATUS_NO_FUND) short_hits++;
    @(negedge clk);
  endtask

  // result side back-pressure
  always @(negedge clk) m_tready <= ($urandom_range(0, 99) >= recv_gap_pct);

  // compare each result beat with the oldest owed reply
  always @(posedge clk) begin : check_replies
    account_reply_t got;
    account_reply_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = account_reply_t'(m_tdata[OUT_BITS-1:0]);
      if (owed_replies.size() == 0) begin
        $error("result beat with no command outstanding: %h", got);
        fails++;
      end else begin
        want = owed_replies.pop_front();
        if (got.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, got.status);
          fails++;
        end
        if (got.refilled !== want.refilled) begin
          $error("refilled: expected %0d, got %0d", want.refilled, got.refilled);
          fails++;
        end
        if (got.branch_now !== want.branch_now) begin
          $error("branch_count_now: expected %0d, got %0d", want.branch_now, got.branch_now);
          fails++;
        end
        if (got.bank_now !== want.bank_now) begin
          $error("bank_count_now: expected %0d, got %0d", want.bank_now, got.bank_now);
          fails++;
        end
      end
    end
  end

  initial begin
    table_row_t row;
    account_reply_t none;
    logic [CNT_W-1:0] new_level;
    logic [CNT_W-1:0] new_pool [NUM_TYPES];
    int guard;

    clk = 1'b0;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    m_tready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    fails = 0;
    cmds_sent = 0;
    refill_hits = 0;
    short_hits = 0;
    none = '0;
    send_gap_pct = 16;
    recv_gap_pct = 75;

    // shadow state after reset
    watermark = REFILL_RESET;
    outbound_held = '0;
    for (int t = 0; t < NUM_TYPES; t++) begin
      bank_avail[t] = '0;
      pool_init[t] = '0;
      for (int b = 0; b < NUM_BRANCHES; b++) begin
        branch_cnt[b][t] = '0;
        branch_debt[b][t] = '0;
      end
    end

    // directed table: empty pool, refill paths, saturation, watermark extremes
    directed_rows.push_back(known_row(CMD_ALLOC, 0, 0, 1, STATUS_NO_FUND, 0, 0, 0));
    directed_rows.push_back(known_row(CMD_RESERVE, 0, 0, 0, STATUS_OK, 0, 0, 0));
    directed_rows.push_back(known_row(CMD_RESERVE, 0, 0, 1, STATUS_NO_FUND, 0, 0, 0));
    directed_rows.push_back(known_row(CMD_RELOAD, 0, 0, 0, STATUS_OK, 0, 0, 0));
    directed_rows.push_back(known_row(CMD_FREE, 0, 0, 0, STATUS_OK, 0, 0, 0));
    directed_rows.push_back(reg_row(CFG_POOL_MEMORY, 5000));
    directed_rows.push_back(reg_row(CFG_POOL_CPU, CNT_MAX));
    directed_rows.push_back(reg_row(CFG_POOL_GPU, 0));
    directed_rows.push_back(reg_row(CFG_POOL_NETWORK, 100));
    directed_rows.push_back(known_row(CMD_RELOAD, 15, 3, 0, STATUS_OK, 0, 0, 100));
    directed_rows.push_back(known_row(CMD_ALLOC, 0, 0, 10, STATUS_OK, 1, 1014, 3976));
    directed_rows.push_back(known_row(CMD_ALLOC, 0, 0, 2000, STATUS_OK, 1, 38, 2952));
    // refill lands but the retry still falls short
    directed_rows.push_back(known_row(CMD_ALLOC, 1, 3, 500, STATUS_NO_FUND, 1, 100, 0));
    directed_rows.push_back(known_row(CMD_ALLOC, 1, 2, 1, STATUS_NO_FUND, 0, 0, 0));
    directed_rows.push_back(known_row(CMD_FREE, 1, 3, 2000, STATUS_OK, 0, 1024, 1076));
    directed_rows.push_back(known_row(CMD_FREE, 2, 1, CNT_MAX, STATUS_OK, 0, 1024, CNT_MAX));
    directed_rows.push_back(known_row(CMD_RECONCILE, 1, 3, 0, STATUS_OK, 0, 1024, 1076));
    directed_rows.push_back(known_row(CMD_RELEASE, 1, 3, 0, STATUS_OK, 0, 0, 2100));
    directed_rows.push_back(known_row(CMD_RESERVE, 0, 1, CNT_MAX, STATUS_OK, 0, 0, 0));
    directed_rows.push_back(known_row(CMD_RESERVE, 0, 1, 1, STATUS_NO_FUND, 0, 0, 0));
    directed_rows.push_back(cmd_row(CMD_SPARE_A, 0, 0, 0));
    directed_rows.push_back(cmd_row(CMD_SPARE_B, 15, 3, CNT_MAX));
    directed_rows.push_back(reg_row(CFG_REFILL_LEVEL, 0));
    directed_rows.push_back(known_row(CMD_ALLOC, 3, 0, 0, STATUS_OK, 0, 0, 2952));
    directed_rows.push_back(known_row(CMD_ALLOC, 3, 0, 1, STATUS_NO_FUND, 0, 0, 2952));
    directed_rows.push_back(cmd_row(CMD_FREE, 0, 0, 5));
    directed_rows.push_back(cmd_row(CMD_ALLOC, 2, 1, 1));
    directed_rows.push_back(reg_row(CFG_REFILL_LEVEL, CNT_MAX));
    directed_rows.push_back(cmd_row(CMD_RELOAD, 4, 0, 0));
    directed_rows.push_back(cmd_row(CMD_ALLOC, 4, 0, CNT_MAX));
    directed_rows.push_back(cmd_row(CMD_FREE, 4, 0, CNT_MAX));
    directed_rows.push_back(cmd_row(CMD_RECONCILE, 4, 0, 0));

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.is_reg) begin
        wait_drained();
        write_reg(row.op, row.amt);
      end else begin
        send_cmd(row.op, row.br, row.ty, row.amt, row.known, row.want);
      end
    end

    // random phases, each under its own watermark and pool loads
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph / 2)
        0: begin
          send_gap_pct = 16;
          recv_gap_pct = 75;
        end
        1: begin
          send_gap_pct = 75;
          recv_gap_pct = 16;
        end
        default: begin
          send_gap_pct = 0;
          recv_gap_pct = 0;
        end
      endcase
      case (ph)
        0: begin
          new_level = 1024;
          new_pool = '{50000, 3000, 700, 20};
        end
        1: begin
          new_level = 100;
          new_pool = '{1000, 0, 250, 60000};
        end
        2: begin
          new_level = 0;
          new_pool = '{CNT_MAX, CNT_MAX, CNT_MAX, CNT_MAX};
        end
        3: begin
          new_level = CNT_MAX;
          new_pool = '{CNT_MAX, 1, 0, rand48()};
        end
        4: begin
          new_level = CNT_W'($urandom_range(1, 4095));
          new_pool = '{rand48(), rand48(), rand48(), rand48()};
        end
        default: begin
          new_level = rand48();
          for (int t = 0; t < NUM_TYPES; t++) new_pool[t] = CNT_W'($urandom_range(0, 65535));
        end
      endcase
      wait_drained();
      write_reg(CFG_REFILL_LEVEL, new_level);
      for (int t = 0; t < NUM_TYPES; t++)
        write_reg(CFG_IDX_W'(CFG_POOL_MEMORY + t), new_pool[t]);
      send_cmd(CMD_RELOAD, 0, 0, 0, 1'b0, none);

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // now and then let the pipe run dry before the next command
        if ($urandom_range(0, 199) == 0) wait_drained();
        send_cmd(pick_cmd(),
                 ($urandom_range(0, 99) < 70) ? BRANCH_W'($urandom_range(0, 3))
                                              : BRANCH_W'($urandom_range(0, 15)),
                 TYPE_W'($urandom_range(0, 3)), pick_amount(), 1'b0, none);
      end
    end

    s_tvalid <= 1'b0;
    guard = 0;
    while (owed_replies.size() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (8) @(posedge clk);
    if (owed_replies.size() != 0) begin
      $error("%0d replies never arrived", owed_replies.size());
      fails++;
    end

    $display("ran %0d commands over %0d register settings and 3 back-pressure mixes",
             cmds_sent, PHASES + 3);
    $display("%0d allocs pulled a refill, %0d commands came back short", refill_hits, short_hits);
    if (fails == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
